[rtl/pds_pkg.sv]
// ----------------------------------------------------------------------------
// pds_pkg: shared widths, codes and types for the PLL divider search
// Field widths, status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package pds_pkg;

   // field widths
   localparam int TARGET_W      = 30;
   localparam int REF_W         = 27;
   localparam int SEL_W         = 2;
   localparam int STATUS_W      = 3;
   localparam int PREDIV_CODE_W = 3;
   localparam int MULT_CODE_W   = 7;
   localparam int POST_CODE_W   = 3;
   localparam int ERR_W         = 31;
   localparam int VCO_W         = 31;
   localparam int SYSCLK_W      = 30;

   // config port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_VCO_MAX    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYSCLK_MAX = 2'd1;

   localparam logic [VCO_W-1:0]    VCO_MAX_RESET    = 31'd840000000;
   localparam logic [SYSCLK_W-1:0] SYSCLK_MAX_RESET = 30'd252000000;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BUSY     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_HIGH = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SRC  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NO_POST  = 3'd4;

   // reference select codes
   localparam logic [SEL_W-1:0] SEL_POSC = 2'd0;
   localparam logic [SEL_W-1:0] SEL_FRC  = 2'd1;

   // post-divider starts at 32 = 1 << 5
   localparam logic [POST_CODE_W-1:0] POST_CODE_START = 3'b101;
   localparam int POST_SHIFT_W = TARGET_W + 5;

   localparam logic [ERR_W-1:0] NO_ERROR_YET = 31'h7FFF_FFFF;

   // status back from the multiplier divider
   typedef struct packed {
      logic done;
      logic overflow;
   } mdiv_status_type;

endpackage

`default_nettype wire

[rtl/pds_req_if.sv]
// ----------------------------------------------------------------------------
// pds_req_if: request channel of the PLL divider search
// valid/ready handshake carrying one frequency request per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pds_req_if;
   logic                          valid;
   logic                          ready;
   logic [pds_pkg::TARGET_W-1:0]  target_hz;
   logic [pds_pkg::REF_W-1:0]     ref_hz;
   logic [pds_pkg::SEL_W-1:0]     ref_select;
   logic                          pll_in_use;

   modport source (output valid, output target_hz, output ref_hz, output ref_select,
                   output pll_in_use, input ready);
   modport sink   (input valid, input target_hz, input ref_hz, input ref_select,
                   input pll_in_use, output ready);
endinterface

`default_nettype wire

[rtl/pds_rsp_if.sv]
// ----------------------------------------------------------------------------
// pds_rsp_if: result channel of the PLL divider search
// valid/ready handshake carrying one PLL setting per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pds_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pds_pkg::STATUS_W-1:0]      status;
   logic [pds_pkg::PREDIV_CODE_W-1:0] prediv_code;
   logic [pds_pkg::MULT_CODE_W-1:0]   mult_code;
   logic [pds_pkg::POST_CODE_W-1:0]   postdiv_code;
   logic                              input_is_frc;
   logic [pds_pkg::ERR_W-1:0]         best_error_hz;

   modport source (output valid, output status, output prediv_code, output mult_code,
                   output postdiv_code, output input_is_frc, output best_error_hz,
                   input ready);
   modport sink   (input valid, input status, input prediv_code, input mult_code,
                   input postdiv_code, input input_is_frc, input best_error_hz,
                   output ready);
endinterface

`default_nettype wire

[rtl/pds_fin_div.sv]
// ----------------------------------------------------------------------------
// pds_fin_div: bit-serial divider for the PLL input frequency
// Divides the reference frequency by the pre-divider, one quotient bit
// per cycle; the quotient shifts into the dividend register.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_fin_div #(
   parameter int DVS_W = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [pds_pkg::REF_W-1:0]  dividend,
   input  wire logic [DVS_W-1:0]           divisor,
   output logic                            done,
   output logic [pds_pkg::REF_W-1:0]       quotient
);

   localparam int RW    = pds_pkg::REF_W;
   localparam int CNT_W = $clog2(RW);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RW - 1);

   logic [RW-1:0]    num_ff, num_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, num_ff[RW-1]};
      ge      = trial >= {1'b0, dvs_ff};
      diff    = trial - {1'b0, dvs_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_LAST;
         run_in = 1'b1;
      end else if (run_ff) begin
         // trial < 2*divisor, so the partial remainder fits DVS_W bits
         rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         num_in = {num_ff[RW-2:0], ge};
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

`default_nettype wire

[rtl/pds_mult_div.sv]
// ----------------------------------------------------------------------------
// pds_mult_div: short restoring divider for the PLL multiplier
// Finds VCO / fin with a quotient of Q_W bits, one bit per cycle, and
// flags overflow when the quotient would not fit.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_mult_div #(
   parameter int Q_W = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [pds_pkg::VCO_W-1:0]   dividend,
   input  wire logic [pds_pkg::REF_W-1:0]   divisor,
   output pds_pkg::mdiv_status_type         status,
   output logic [Q_W-1:0]                   quotient,
   output logic [pds_pkg::VCO_W-1:0]        remainder
);

   localparam int VW   = pds_pkg::VCO_W;
   localparam int DW   = VW + Q_W;
   localparam int CW   = $clog2(Q_W + 1);
   localparam logic [CW-1:0] CNT_TOP = CW'(Q_W);

   logic [VW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  dvs_ff, dvs_in;
   logic [Q_W-1:0] q_ff, q_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           run_ff, run_in;
   logic           done_ff, done_in;
   logic           ovf_ff, ovf_in;
   logic           ge;
   logic [VW-1:0]  diff;

   always_comb begin
      ge      = {{Q_W{1'b0}}, rem_ff} >= dvs_ff;
      diff    = rem_ff - dvs_ff[VW-1:0];
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      ovf_in  = ovf_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend;
         dvs_in = DW'(divisor) << Q_W;
         cnt_in = CNT_TOP;
         run_in = 1'b1;
         ovf_in = 1'b0;
      end else if (run_ff) begin
         if (cnt_ff == CNT_TOP) begin
            // quotient of Q_W+1 bits or more: out of range
            if (ge) begin
               run_in  = 1'b0;
               done_in = 1'b1;
               ovf_in  = 1'b1;
            end else begin
               dvs_in = dvs_ff >> 1;
               cnt_in = cnt_ff - 1'b1;
            end
         end else begin
            if (ge) begin
               rem_in = diff;
            end
            q_in   = {q_ff[Q_W-2:0], ge};
            dvs_in = dvs_ff >> 1;
            if (cnt_ff == '0) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         ovf_ff  <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         ovf_ff  <= ovf_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign status.done     = done_ff;
   assign status.overflow = ovf_ff;
   assign quotient        = q_ff;
   assign remainder       = rem_ff;

endmodule

`default_nettype wire

[rtl/pll_divider_search.sv]
// ----------------------------------------------------------------------------
// pll_divider_search: PLL pre-divider / multiplier / post-divider search
// Turns a requested system clock into PLL settings with serial dividers.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  carries one request per beat: target frequency, reference
//            frequency, reference select and the PLL-in-use flag.
//   rsp_bus  returns exactly one setting per request: status, codes for
//            pre-divider, multiplier and post-divider, input select and
//            the absolute VCO error of the chosen setting.
//   csr_*    write-only limits (VCO max, system clock max); write only
//            while no request is in flight.
// Sequence: a rejected request skips the search and goes through the
//   done state to the output register. An accepted one first runs the
//   post-divider search, then for each pre-divider a bit-serial division
//   of the reference and a short division for the multiplier, then
//   loads the output register. One request at a time.
// Reset: synchronous; returns to idle, restores the limit registers,
//   drops any result held in the output register.
// Stall: the result sits in an output register; the next request is
//   taken while it waits, and a finished search waits for it to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_divider_search #(
   parameter int MAX_PREDIV = 8,
   parameter int MAX_MULT   = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   pds_req_if.sink                                req_bus,
   pds_rsp_if.source                              rsp_bus,
   input  wire logic                              csr_we,
   input  wire logic [pds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pds_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PW  = $clog2(MAX_PREDIV + 1);   // pre-divider width
   localparam int Q_W = $clog2(MAX_MULT + 1);     // multiplier width
   localparam int SHW = pds_pkg::POST_SHIFT_W;
   localparam int VW  = pds_pkg::VCO_W;
   localparam int EW  = pds_pkg::ERR_W;

   localparam logic [PW-1:0]  PRE_LAST   = PW'(MAX_PREDIV);
   localparam logic [PW-1:0]  PRE_FIRST  = PW'(1);
   localparam logic [Q_W-1:0] MULT_LIMIT = Q_W'(MAX_MULT);
   localparam logic [Q_W-1:0] MULT_FIRST = Q_W'(1);

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_POST       = 7'b0000010,
      ST_FIN_START  = 7'b0000100,
      ST_FIN_WAIT   = 7'b0001000,
      ST_MULT_START = 7'b0010000,
      ST_MULT_WAIT  = 7'b0100000,
      ST_DONE       = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // limit registers
   logic [VW-1:0]                 vco_max_ff, vco_max_in;
   logic [pds_pkg::SYSCLK_W-1:0]  sysclk_max_ff, sysclk_max_in;

   // request working registers
   logic [pds_pkg::REF_W-1:0]     ref_ff, ref_in;
   logic                          frc_ff, frc_in;
   logic [pds_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [SHW-1:0]                vco_ff, vco_in;        // target << post code
   logic [pds_pkg::POST_CODE_W-1:0] post_code_ff, post_code_in;
   logic [PW-1:0]                 pre_ff, pre_in;

   // best setting so far
   logic [PW-1:0]                 best_pre_ff, best_pre_in;
   logic [Q_W-1:0]                best_mult_ff, best_mult_in;
   logic [EW-1:0]                 best_err_ff, best_err_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [pds_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [pds_pkg::PREDIV_CODE_W-1:0]  rsp_pre_ff, rsp_pre_in;
   logic [pds_pkg::MULT_CODE_W-1:0]    rsp_mult_ff, rsp_mult_in;
   logic [pds_pkg::POST_CODE_W-1:0]    rsp_post_ff, rsp_post_in;
   logic                               rsp_frc_ff, rsp_frc_in;
   logic [EW-1:0]                      rsp_err_ff, rsp_err_in;

   logic                          req_accept;
   logic                          fin_start;
   logic                          fin_done;
   logic [pds_pkg::REF_W-1:0]     fin_q;
   logic                          mult_start;
   pds_pkg::mdiv_status_type      mstat;
   logic [Q_W-1:0]                mdiv_q;
   logic [VW-1:0]                 mdiv_rem;
   logic                          cand_ok;
   logic [PW-1:0]                 pre_m1;
   logic [Q_W-1:0]                mult_m1;

   // ------------------------------------------------------------------
   // serial dividers
   // ------------------------------------------------------------------
   pds_fin_div #(
      .DVS_W (PW)
   ) u_fin_div (
      .clock    (clock),
      .reset    (reset),
      .start    (fin_start),
      .dividend (ref_ff),
      .divisor  (pre_ff),
      .done     (fin_done),
      .quotient (fin_q)
   );

   pds_mult_div #(
      .Q_W (Q_W)
   ) u_mult_div (
      .clock     (clock),
      .reset     (reset),
      .start     (mult_start),
      .dividend  (vco_ff[VW-1:0]),
      .divisor   (fin_q),
      .status    (mstat),
      .quotient  (mdiv_q),
      .remainder (mdiv_rem)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign fin_start     = (state_ff == ST_FIN_START);
   assign mult_start    = (state_ff == ST_MULT_START);

   // a trial counts only for multipliers 1..MAX_MULT
   assign cand_ok = !mstat.overflow && (mdiv_q != '0) && (mdiv_q <= MULT_LIMIT);

   assign pre_m1  = best_pre_ff - 1'b1;
   assign mult_m1 = best_mult_ff - 1'b1;

   // ------------------------------------------------------------------
   // config writes
   // ------------------------------------------------------------------
   always_comb begin
      vco_max_in    = vco_max_ff;
      sysclk_max_in = sysclk_max_ff;
      if (csr_we) begin
         unique case (csr_index)
            pds_pkg::CSR_VCO_MAX:    vco_max_in    = csr_wdata;
            pds_pkg::CSR_SYSCLK_MAX: sysclk_max_in = csr_wdata[pds_pkg::SYSCLK_W-1:0];
            default: ;   // unmapped index: ignored
         endcase
      end
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      ref_in        = ref_ff;
      frc_in        = frc_ff;
      status_in     = status_ff;
      vco_in        = vco_ff;
      post_code_in  = post_code_ff;
      pre_in        = pre_ff;
      best_pre_in   = best_pre_ff;
      best_mult_in  = best_mult_ff;
      best_err_in   = best_err_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pre_in    = rsp_pre_ff;
      rsp_mult_in   = rsp_mult_ff;
      rsp_post_in   = rsp_post_ff;
      rsp_frc_in    = rsp_frc_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ref_in       = req_bus.ref_hz;
               frc_in       = (req_bus.ref_select == pds_pkg::SEL_FRC);
               vco_in       = SHW'(req_bus.target_hz) << pds_pkg::POST_CODE_START;
               post_code_in = pds_pkg::POST_CODE_START;
               pre_in       = PRE_FIRST;
               best_pre_in  = PRE_FIRST;
               best_mult_in = MULT_FIRST;
               best_err_in  = pds_pkg::NO_ERROR_YET;
               // first failing check wins
               if (req_bus.pll_in_use) begin
                  status_in = pds_pkg::STATUS_BUSY;
               end else if (req_bus.target_hz > pds_pkg::TARGET_W'(sysclk_max_ff)) begin
                  status_in = pds_pkg::STATUS_TOO_HIGH;
               end else if (req_bus.ref_select != pds_pkg::SEL_POSC &&
                            req_bus.ref_select != pds_pkg::SEL_FRC) begin
                  status_in = pds_pkg::STATUS_BAD_SRC;
               end else if (req_bus.ref_hz < pds_pkg::REF_W'(MAX_PREDIV)) begin
                  // keeps ref / prediv above zero
                  status_in = pds_pkg::STATUS_BAD_SRC;
               end else begin
                  status_in = pds_pkg::STATUS_OK;
               end
               state_in = (status_in == pds_pkg::STATUS_OK) ? ST_POST : ST_DONE;
            end
         end
         ST_POST: begin
            // halve the post-divider while the VCO would exceed its limit
            if (post_code_ff == '0) begin
               status_in = pds_pkg::STATUS_NO_POST;
               state_in  = ST_DONE;
            end else if (vco_ff > SHW'(vco_max_ff)) begin
               vco_in       = vco_ff >> 1;
               post_code_in = post_code_ff - 1'b1;
            end else begin
               state_in = ST_FIN_START;
            end
         end
         ST_FIN_START: begin
            state_in = ST_FIN_WAIT;
         end
         ST_FIN_WAIT: begin
            if (fin_done) begin
               state_in = ST_MULT_START;
            end
         end
         ST_MULT_START: begin
            state_in = ST_MULT_WAIT;
         end
         ST_MULT_WAIT: begin
            if (mstat.done) begin
               // error is the division remainder; strict compare keeps the first
               if (cand_ok && (mdiv_rem < best_err_ff)) begin
                  best_pre_in  = pre_ff;
                  best_mult_in = mdiv_q;
                  best_err_in  = mdiv_rem;
               end
               if (pre_ff == PRE_LAST) begin
                  state_in = ST_DONE;
               end else begin
                  pre_in   = pre_ff + 1'b1;
                  state_in = ST_FIN_START;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (status_ff == pds_pkg::STATUS_OK) begin
                  rsp_pre_in  = pds_pkg::PREDIV_CODE_W'(pre_m1);
                  rsp_mult_in = pds_pkg::MULT_CODE_W'(mult_m1);
                  rsp_post_in = post_code_ff;
                  rsp_frc_in  = frc_ff;
                  rsp_err_in  = best_err_ff;
               end else begin
                  rsp_pre_in  = '0;
                  rsp_mult_in = '0;
                  rsp_post_in = '0;
                  rsp_frc_in  = 1'b0;
                  rsp_err_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vco_max_ff    <= pds_pkg::VCO_MAX_RESET;
         sysclk_max_ff <= pds_pkg::SYSCLK_MAX_RESET;
         rsp_valid_ff  <= 1'b0;
         best_pre_ff   <= PRE_FIRST;
         best_mult_ff  <= MULT_FIRST;
         best_err_ff   <= pds_pkg::NO_ERROR_YET;
      end else begin
         state_ff      <= state_in;
         vco_max_ff    <= vco_max_in;
         sysclk_max_ff <= sysclk_max_in;
         rsp_valid_ff  <= rsp_valid_in;
         best_pre_ff   <= best_pre_in;
         best_mult_ff  <= best_mult_in;
         best_err_ff   <= best_err_in;
      end
      ref_ff        <= ref_in;
      frc_ff        <= frc_in;
      status_ff     <= status_in;
      vco_ff        <= vco_in;
      post_code_ff  <= post_code_in;
      pre_ff        <= pre_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pre_ff    <= rsp_pre_in;
      rsp_mult_ff   <= rsp_mult_in;
      rsp_post_ff   <= rsp_post_in;
      rsp_frc_ff    <= rsp_frc_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.prediv_code   = rsp_pre_ff;
   assign rsp_bus.mult_code     = rsp_mult_ff;
   assign rsp_bus.postdiv_code  = rsp_post_ff;
   assign rsp_bus.input_is_frc  = rsp_frc_ff;
   assign rsp_bus.best_error_hz = rsp_err_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_err_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != pds_pkg::STATUS_OK) |->
         (rsp_pre_ff == '0) && (rsp_mult_ff == '0) && (rsp_post_ff == '0) &&
         !rsp_frc_ff && (rsp_err_ff == '0))
      else $error("error beat carries nonzero setting fields");

   a_ok_post_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == pds_pkg::STATUS_OK) |->
         (rsp_post_ff != '0) && (rsp_post_ff <= pds_pkg::POST_CODE_START))
      else $error("ok beat with post-divider code out of range");

   a_best_mult_range: assert property (@(posedge clock) disable iff (reset)
      (best_err_ff != pds_pkg::NO_ERROR_YET) |->
         (best_mult_ff != '0) && (best_mult_ff <= MULT_LIMIT))
      else $error("kept multiplier outside 1..MAX_MULT");

   a_rem_below_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULT_WAIT) && mstat.done && !mstat.overflow |->
         (mdiv_rem < VW'(fin_q)))
      else $error("multiplier division remainder not below input frequency");

endmodule

`default_nettype wire

[test/pll_divider_search_test.sv]
// ----------------------------------------------------------------------------
// pll_divider_search_test: self-checking bench for the PLL divider search
// Sends frequency requests through random source gaps and sink stalls under
// several limit settings. Each beat is checked field by field against an
// in-bench search of post-divider, pre-divider and multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_divider_search_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PREDIV = 8;
   localparam int MAX_MULT   = 128;

   // register indexes past the two real limits; writes there are dropped
   localparam logic [pds_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [pds_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   // settle time after the last result, enough for a rejected request
   localparam int SETTLE_CYCLES = 16;

   typedef struct packed {
      logic [pds_pkg::TARGET_W-1:0] target_hz;
      logic [pds_pkg::REF_W-1:0]    ref_hz;
      logic [pds_pkg::SEL_W-1:0]    ref_select;
      logic                         pll_in_use;
   } pll_request_type;

   typedef struct packed {
      logic [pds_pkg::STATUS_W-1:0]      status;
      logic [pds_pkg::PREDIV_CODE_W-1:0] prediv_code;
      logic [pds_pkg::MULT_CODE_W-1:0]   mult_code;
      logic [pds_pkg::POST_CODE_W-1:0]   postdiv_code;
      logic                              input_is_frc;
      logic [pds_pkg::ERR_W-1:0]         best_error_hz;
   } pll_setting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_we;
   logic [pds_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pds_pkg::CSR_DATA_W-1:0] csr_wdata;

   pds_req_if req_bus();
   pds_rsp_if rsp_bus();

   pll_divider_search #(
      .MAX_PREDIV(MAX_PREDIV),
      .MAX_MULT  (MAX_MULT)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // bench copy of the limit registers
   logic [pds_pkg::VCO_W-1:0]    vco_limit;
   logic [pds_pkg::SYSCLK_W-1:0] sysclk_limit;

   pll_request_type request_queue[$];   // requests not yet on the bus
   pll_setting_type setting_queue[$];   // settings owed by the block, oldest first
   pll_request_type on_bus;             // request currently offered
   int  mismatch_count = 0;
   int  send_gap;
   int  stall_left;
   bit  steady = 1'b0;                  // no idling on either side when set

   // --------------------------------------------------------------------------
   // Search: reject checks in priority order, then halve the post-divider
   // from 32 until target * post fits the VCO limit, then try each
   // pre-divider and keep the first strictly smallest VCO error.
   // --------------------------------------------------------------------------
   function automatic pll_setting_type search_setting(input pll_request_type rq);
      pll_setting_type r;
      logic [63:0]   tgt;
      logic [63:0]   postdiv;
      logic [63:0]   vco;
      logic [63:0]   fin;
      logic [63:0]   mult;
      logic [63:0]   prod;
      logic [63:0]   err;
      logic [63:0]   best_err;
      logic [63:0]   best_mult;
      int            best_pre;
      int            post_code;
      r   = '0;
      tgt = 64'(rq.target_hz);
      if (rq.pll_in_use) begin
         r.status = pds_pkg::STATUS_BUSY;
      end else if (rq.target_hz > sysclk_limit) begin
         r.status = pds_pkg::STATUS_TOO_HIGH;
      end else if ((rq.ref_select != pds_pkg::SEL_POSC &&
                    rq.ref_select != pds_pkg::SEL_FRC) ||
                   rq.ref_hz < MAX_PREDIV) begin
         // unknown source, or a reference that a pre-divider could zero
         r.status = pds_pkg::STATUS_BAD_SRC;
      end else begin
         postdiv   = 64'd32;
         post_code = pds_pkg::POST_CODE_START;
         while (tgt * postdiv > 64'(vco_limit) && postdiv >= 2) begin
            postdiv   = postdiv >> 1;
            post_code = post_code - 1;
         end
         if (postdiv < 2) begin
            r.status = pds_pkg::STATUS_NO_POST;
         end else begin
            vco       = tgt * postdiv;
            best_pre  = 1;
            best_mult = 64'd1;
            best_err  = 64'(pds_pkg::NO_ERROR_YET);
            for (int p = 1; p <= MAX_PREDIV; p++) begin
               fin  = 64'(rq.ref_hz) / p;
               mult = vco / fin;
               prod = fin * mult;
               err  = (prod > vco) ? prod - vco : vco - prod;
               if (mult != 0 && mult <= MAX_MULT && err < best_err) begin
                  best_pre  = p;
                  best_mult = mult;
                  best_err  = err;
               end
            end
            // no usable multiplier leaves codes 0 and the all-ones error
            r.status        = pds_pkg::STATUS_OK;
            r.prediv_code   = pds_pkg::PREDIV_CODE_W'(best_pre - 1);
            r.mult_code     = pds_pkg::MULT_CODE_W'(best_mult - 1);
            r.postdiv_code  = pds_pkg::POST_CODE_W'(post_code);
            r.input_is_frc  = (rq.ref_select == pds_pkg::SEL_FRC);
            r.best_error_hz = pds_pkg::ERR_W'(best_err);
         end
      end
      return r;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // --------------------------------------------------------------------------
   // Request driver: offers queued requests, predicts on each accepted beat.
   // Random gaps between beats unless steady.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            setting_queue.push_back(search_setting(on_bus));
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               req_bus.valid <= 1'b0;
               send_gap      <= send_gap - 1;
            end else if (request_queue.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
               req_bus.valid <= 1'b0;
               send_gap      <= $urandom_range(0, 6);
            end else begin
               on_bus = request_queue.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.target_hz  <= on_bus.target_hz;
               req_bus.ref_hz     <= on_bus.ref_hz;
               req_bus.ref_select <= on_bus.ref_select;
               req_bus.pll_in_use <= on_bus.pll_in_use;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Result monitor: checks each beat against the oldest prediction.
   // Ready drops in random bursts unless steady.
   // --------------------------------------------------------------------------
   pll_setting_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (setting_queue.size() == 0) begin
               $error("result beat with no request outstanding");
               mismatch_count++;
            end else begin
               want = setting_queue.pop_front();
               check_field("status", want.status, rsp_bus.status);
               check_field("prediv_code", want.prediv_code, rsp_bus.prediv_code);
               check_field("mult_code", want.mult_code, rsp_bus.mult_code);
               check_field("postdiv_code", want.postdiv_code, rsp_bus.postdiv_code);
               check_field("input_is_frc", want.input_is_frc, rsp_bus.input_is_frc);
               check_field("best_error_hz", want.best_error_hz, rsp_bus.best_error_hz);
            end
         end
         if (steady) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= stall_left - 1;
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= $urandom_range(0, 6);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------
   task automatic push_request(input logic [pds_pkg::TARGET_W-1:0] target,
                               input logic [pds_pkg::REF_W-1:0] refclk,
                               input logic [pds_pkg::SEL_W-1:0] sel, input logic busy);
      pll_request_type rq;
      rq.target_hz  = target;
      rq.ref_hz     = refclk;
      rq.ref_select = sel;
      rq.pll_in_use = busy;
      request_queue.push_back(rq);
   endtask

   // Mostly well-formed requests within the current limits; the rest are
   // busy, out-of-range, bad-source or full-width noise.
   task automatic queue_random(input int count);
      logic [pds_pkg::TARGET_W-1:0] target;
      logic [pds_pkg::REF_W-1:0]    refclk;
      logic [pds_pkg::SEL_W-1:0]    sel;
      logic                         busy;
      int                           pick;
      for (int n = 0; n < count; n++) begin
         busy = ($urandom_range(0, 15) == 0);
         sel  = ($urandom_range(0, 6) == 0) ? pds_pkg::SEL_W'($urandom_range(2, 3))
                                            : pds_pkg::SEL_W'($urandom_range(0, 1));
         pick = $urandom_range(0, 9);
         if (pick == 0)
            refclk = pds_pkg::REF_W'($urandom_range(0, MAX_PREDIV - 1));
         else if (pick <= 2)
            refclk = pds_pkg::REF_W'($urandom);
         else
            refclk = pds_pkg::REF_W'($urandom_range(1_000_000, 64_000_000));
         pick = $urandom_range(0, 19);
         if (pick <= 1)
            target = pds_pkg::TARGET_W'($urandom_range(sysclk_limit,
                                                       (1 << pds_pkg::TARGET_W) - 1));
         else if (pick <= 3)
            target = pds_pkg::TARGET_W'($urandom);
         else if (pick == 4)
            target = pds_pkg::TARGET_W'($urandom_range(0, 1000));
         else
            target = pds_pkg::TARGET_W'($urandom_range(0, sysclk_limit));
         push_request(target, refclk, sel, busy);
      end
   endtask

   // Block the caller until every request has been answered.
   task automatic wait_drained();
      while (request_queue.size() != 0 || req_bus.valid || setting_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the bench copy keeps only the register's width.
   task automatic write_limit(input logic [pds_pkg::CSR_IDX_W-1:0] index,
                              input logic [pds_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (index == pds_pkg::CSR_VCO_MAX)
         vco_limit = pds_pkg::VCO_W'(value);
      else if (index == pds_pkg::CSR_SYSCLK_MAX)
         sysclk_limit = pds_pkg::SYSCLK_W'(value);
   endtask

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      req_bus.valid      = 1'b0;
      req_bus.target_hz  = '0;
      req_bus.ref_hz     = '0;
      req_bus.ref_select = pds_pkg::SEL_POSC;
      req_bus.pll_in_use = 1'b0;
      rsp_bus.ready      = 1'b0;
      csr_we             = 1'b0;
      csr_index          = pds_pkg::CSR_VCO_MAX;
      csr_wdata          = '0;
      vco_limit          = pds_pkg::VCO_MAX_RESET;
      sysclk_limit       = pds_pkg::SYSCLK_MAX_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset limits: every reject path and the plain searches
      push_request('1, '1, pds_pkg::SEL_W'(3), 1'b1);           // busy beats everything
      push_request('0, '0, pds_pkg::SEL_POSC, 1'b1);
      push_request(30'd252_000_001, 27'd24_000_000, pds_pkg::SEL_POSC, 1'b0); // too high
      push_request('1, 27'd24_000_000, pds_pkg::SEL_FRC, 1'b0);
      push_request(30'd100_000_000, 27'd24_000_000, pds_pkg::SEL_W'(2), 1'b0); // bad source
      push_request(30'd100_000_000, 27'd24_000_000, pds_pkg::SEL_W'(3), 1'b0);
      push_request(30'd100_000_000, 27'd7, pds_pkg::SEL_POSC, 1'b0);  // reference too slow
      push_request(30'd200_000_000, 27'd8, pds_pkg::SEL_FRC, 1'b0);   // multipliers too big
      push_request(30'd0, 27'd24_000_000, pds_pkg::SEL_POSC, 1'b0);   // zero target
      push_request(30'd252_000_000, 27'd24_000_000, pds_pkg::SEL_POSC, 1'b0); // at the limit
      push_request(30'd120_000_000, 27'd8_000_000, pds_pkg::SEL_FRC, 1'b0);
      push_request(30'd252_000_000, '1, pds_pkg::SEL_POSC, 1'b0);     // widest reference
      push_request(30'd1, 27'd8, pds_pkg::SEL_POSC, 1'b0);
      push_request(30'd80_000_000, 27'd12_000_000, pds_pkg::SEL_FRC, 1'b0);
      wait_drained();

      // tiny VCO limit: no post-divider fits except for a zero target
      write_limit(pds_pkg::CSR_VCO_MAX, 31'd1);
      write_limit(pds_pkg::CSR_SYSCLK_MAX, '1);        // top bit masked off
      push_request(30'd1, 27'd8, pds_pkg::SEL_POSC, 1'b0);
      push_request(30'd0, 27'd8_000_000, pds_pkg::SEL_FRC, 1'b0);
      push_request('1, '1, pds_pkg::SEL_FRC, 1'b0);
      queue_random(40);
      wait_drained();

      // widest VCO limit
      write_limit(pds_pkg::CSR_VCO_MAX, '1);
      queue_random(150);
      wait_drained();

      // high VCO and system clock limits
      write_limit(pds_pkg::CSR_VCO_MAX, 31'd2_000_000_000);
      write_limit(pds_pkg::CSR_SYSCLK_MAX, 31'd1_000_000_000);
      queue_random(150);
      wait_drained();

      // spare indexes must not disturb the limits
      write_limit(pds_pkg::CSR_VCO_MAX, 31'(pds_pkg::VCO_MAX_RESET));
      write_limit(pds_pkg::CSR_SYSCLK_MAX, 31'(pds_pkg::SYSCLK_MAX_RESET));
      write_limit(CSR_SPARE_2, '1);
      write_limit(CSR_SPARE_3, 31'd1);
      queue_random(150);
      wait_drained();

      // random limits, full rate on both sides
      write_limit(pds_pkg::CSR_VCO_MAX, 31'($urandom_range(1_000_000, 2_000_000_000)));
      write_limit(pds_pkg::CSR_SYSCLK_MAX, 31'($urandom_range(1, 1_000_000_000)));
      steady = 1'b1;
      queue_random(140);
      wait_drained();

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
